/* rtl/prle_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and unit-width helpers for the PackBits packer.
package prle_pkg;

   // Width of the buffer fill counter; holds a full literal plus a capped run.
   localparam int FILL_W = 8;

   // Repeat length that turns buffered literals into a run, and the run cap.
   localparam int MIN_RUN = 6;
   localparam int MAX_RUN = 128;

   typedef enum logic [1:0] {
      USZ_8  = 2'd0,
      USZ_16 = 2'd1,
      USZ_32 = 2'd2
   } prle_usize_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EVAL = 6'b000010,
      ST_HDR  = 6'b000100,
      ST_RUNV = 6'b001000,
      ST_LIT  = 6'b010000,
      ST_POST = 6'b100000
   } prle_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic take;       // latch the accepted request
      logic eval;       // apply the packing decision for the latched unit
      logic post;       // deferred buffer restart and end-of-row flush set-up
      logic emit_hdr;   // send the packet header
      logic emit_runv;  // send the repeated unit of a run
      logic emit_lit;   // send the next buffered literal unit
      logic last;       // the unit sent now closes the row
   } prle_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_ready;  // output register can take a unit this cycle
      logic ev_pkt;     // the latched unit closes a packet
      logic pkt_run;    // the loaded packet is a run
      logic lit_more;   // more literal units follow the one being sent
      logic end_item;   // the latched unit ends the row
   } prle_status_type;

   function automatic logic [31:0] unit_mask(input logic [1:0] size);
      logic [31:0] m;
      unique case (size)
         USZ_8:   m = 32'h0000_00FF;
         USZ_16:  m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [2:0] unit_bytes(input logic [1:0] size);
      logic [2:0] b;
      unique case (size)
         USZ_8:   b = 3'd1;
         USZ_16:  b = 3'd2;
         default: b = 3'd4;
      endcase
      return b;
   endfunction

endpackage

/* rtl/prle_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the PackBits packer.
module prle_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  prle_pkg::prle_status_type status,
   output prle_pkg::prle_cmd_type    cmd
);

   prle_pkg::prle_state_type state_ff, state_in;
   logic                     phase_ff, phase_in;   // high while the end-of-row packet drains

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prle_pkg::ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != prle_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         prle_pkg::ST_IDLE: begin
            phase_in = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = prle_pkg::ST_EVAL;
            end
         end
         prle_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.ev_pkt) begin
               state_in = prle_pkg::ST_HDR;
            end else if (status.end_item) begin
               state_in = prle_pkg::ST_POST;
            end else begin
               state_in = prle_pkg::ST_IDLE;
            end
         end
         prle_pkg::ST_HDR: begin
            if (status.out_ready) begin
               cmd.emit_hdr = 1'b1;
               state_in = status.pkt_run ? prle_pkg::ST_RUNV : prle_pkg::ST_LIT;
            end
         end
         prle_pkg::ST_RUNV: begin
            if (status.out_ready) begin
               cmd.emit_runv = 1'b1;
               cmd.last      = phase_ff;
               state_in      = phase_ff ? prle_pkg::ST_IDLE : prle_pkg::ST_POST;
            end
         end
         prle_pkg::ST_LIT: begin
            if (status.out_ready) begin
               cmd.emit_lit = 1'b1;
               cmd.last     = phase_ff && !status.lit_more;
               if (!status.lit_more) begin
                  state_in = phase_ff ? prle_pkg::ST_IDLE : prle_pkg::ST_POST;
               end
            end
         end
         prle_pkg::ST_POST: begin
            cmd.post = 1'b1;
            if (status.end_item) begin
               phase_in = 1'b1;
               state_in = prle_pkg::ST_HDR;
            end else begin
               state_in = prle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prle_pkg::ST_IDLE;
            phase_in = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/prle_datapath.sv */
`timescale 1ns / 1ps
// Packing state, literal buffer memory and output register of the PackBits packer.
module prle_datapath #(
   parameter int MAX_LITERAL = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               req_unit_value,
   input  logic                      req_row_end,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_unit_size,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [31:0]               rsp_packed_unit,
   output logic                      rsp_packed_last,
   output logic [15:0]               rsp_packed_bytes,
   input  prle_pkg::prle_cmd_type    cmd,
   output prle_pkg::prle_status_type status
);

   localparam int DEPTH = MAX_LITERAL + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = prle_pkg::FILL_W;

   logic [1:0]    unit_size_ff;
   logic [31:0]   cur_ff;
   logic          end_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rb_ff, rb_in;
   logic          in_run_ff, in_run_in;
   logic [31:0]   prev_ff;
   logic          row_start_ff;
   logic [15:0]   total_ff;
   logic          pend_ff;
   logic [FW-1:0] pkt_cnt_ff;
   logic          pkt_run_ff;
   logic [31:0]   pkt_val_ff;
   logic [AW-1:0] idx_ff;
   logic [31:0]   rd_q_ff;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_unit_ff;
   logic          rsp_last_ff;
   logic [15:0]   rsp_bytes_ff;

   logic [31:0]   store_mem [DEPTH];

   // Packing decision for the latched unit.
   logic [FW-1:0] fill_inc, run_len, ev_cnt;
   logic          same, ev_pkt, ev_run, ev_we, ev_pend;
   logic [AW-1:0] ev_waddr;

   assign fill_inc = fill_ff + FW'(1);
   assign run_len  = fill_inc - FW'(rb_ff);
   assign same     = (cur_ff == prev_ff);

   always_comb begin
      ev_pkt    = 1'b0;
      ev_run    = 1'b0;
      ev_cnt    = fill_ff;
      ev_we     = 1'b0;
      ev_waddr  = '0;
      ev_pend   = 1'b0;
      fill_in   = fill_inc;
      rb_in     = rb_ff;
      in_run_in = in_run_ff;
      if (row_start_ff) begin
         fill_in   = FW'(1);
         rb_in     = '0;
         in_run_in = 1'b0;
         ev_we     = 1'b1;
      end else if (!in_run_ff) begin
         ev_we    = (fill_ff < FW'(DEPTH));
         ev_waddr = fill_ff[AW-1:0];
         if (fill_inc > FW'(MAX_LITERAL)) begin
            // buffer full: flush it, restart once the flush has read it
            ev_pkt    = 1'b1;
            ev_cnt    = fill_ff;
            fill_in   = FW'(1);
            rb_in     = '0;
            in_run_in = 1'b0;
            ev_pend   = 1'b1;
         end else if (same) begin
            if (run_len >= FW'(prle_pkg::MIN_RUN)) begin
               in_run_in = 1'b1;
               if (rb_ff != '0) begin
                  ev_pkt = 1'b1;
                  ev_cnt = FW'(rb_ff);
               end
            end else if (rb_ff == '0) begin
               in_run_in = 1'b1;
            end
         end else begin
            rb_in = fill_ff[AW-1:0];
         end
      end else begin
         if (!same || run_len > FW'(prle_pkg::MAX_RUN)) begin
            ev_pkt    = 1'b1;
            ev_run    = 1'b1;
            ev_cnt    = fill_ff - FW'(rb_ff);
            fill_in   = FW'(1);
            rb_in     = '0;
            in_run_in = 1'b0;
            ev_we     = 1'b1;
         end
      end
   end

   // Emission.
   logic          out_ready, emit, lit_more, rd_en, mem_we;
   logic [AW-1:0] rd_addr, mem_waddr;
   logic [31:0]   cnt_m1, hdr_val, emit_raw, emit_val, mask;
   logic [16:0]   total_sum;
   logic [15:0]   total_sat;

   assign mask      = prle_pkg::unit_mask(unit_size_ff);
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = cmd.emit_hdr || cmd.emit_runv || cmd.emit_lit;
   assign lit_more  = (FW'(idx_ff) + FW'(1)) < pkt_cnt_ff;
   assign rd_en     = (cmd.emit_hdr && !pkt_run_ff) || (cmd.emit_lit && lit_more);
   assign rd_addr   = cmd.emit_hdr ? '0 : AW'(idx_ff + 1'b1);
   assign mem_we    = (cmd.eval && ev_we) || (cmd.post && pend_ff);
   assign mem_waddr = cmd.eval ? ev_waddr : '0;

   assign cnt_m1  = 32'(pkt_cnt_ff) - 32'd1;
   assign hdr_val = pkt_run_ff ? (32'd0 - cnt_m1) : cnt_m1;

   always_comb begin
      if (cmd.emit_hdr) begin
         emit_raw = hdr_val;
      end else if (cmd.emit_runv) begin
         emit_raw = pkt_val_ff;
      end else begin
         emit_raw = rd_q_ff;
      end
   end

   assign emit_val  = emit_raw & mask;
   assign total_sum = {1'b0, total_ff} + 17'(prle_pkg::unit_bytes(unit_size_ff));
   assign total_sat = total_sum[16] ? 16'hFFFF : total_sum[15:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= cur_ff;
      end
      if (rd_en) begin
         rd_q_ff <= store_mem[rd_addr];
         idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_size_ff <= 2'd0;
         fill_ff      <= '0;
         rb_ff        <= '0;
         in_run_ff    <= 1'b0;
         prev_ff      <= '0;
         row_start_ff <= 1'b1;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unit_size_ff <= csr_unit_size;
         end
         if (cmd.eval) begin
            fill_ff      <= fill_in;
            rb_ff        <= rb_in;
            in_run_ff    <= in_run_in;
            prev_ff      <= cur_ff;
            row_start_ff <= 1'b0;
            pend_ff      <= ev_pend;
            if (row_start_ff) begin
               total_ff <= '0;
            end
         end
         if (cmd.post) begin
            pend_ff <= 1'b0;
            if (end_ff) begin
               row_start_ff <= 1'b1;
               in_run_ff    <= 1'b0;
               fill_ff      <= '0;
               rb_ff        <= '0;
            end
         end
         if (emit) begin
            total_ff     <= total_sat;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cur_ff <= req_unit_value & mask;
         end_ff <= req_row_end;
      end
      if (cmd.eval && ev_pkt) begin
         pkt_cnt_ff <= ev_cnt;
         pkt_run_ff <= ev_run;
         pkt_val_ff <= prev_ff;
      end else if (cmd.post && end_ff) begin
         pkt_cnt_ff <= in_run_ff ? (fill_ff - FW'(rb_ff)) : fill_ff;
         pkt_run_ff <= in_run_ff;
         pkt_val_ff <= prev_ff;
      end
      if (emit) begin
         rsp_unit_ff  <= emit_val;
         rsp_last_ff  <= cmd.last;
         rsp_bytes_ff <= cmd.last ? total_sat : 16'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_unit  = rsp_unit_ff;
   assign rsp_packed_last  = rsp_last_ff;
   assign rsp_packed_bytes = rsp_bytes_ff;

   assign status.out_ready = out_ready;
   assign status.ev_pkt    = ev_pkt;
   assign status.pkt_run   = pkt_run_ff;
   assign status.lit_more  = lit_more;
   assign status.end_item  = end_ff;

endmodule

/* rtl/packbits_rle_packer.sv */
`timescale 1ns / 1ps
// PackBits run-length packer: top level joining the controller and the datapath.
// Sequence: a request is taken in IDLE and decided in EVAL the cycle after; a packet it closes
//   is sent from HDR (header) and RUNV or LIT (data), the row-end flush going through POST first.
// A new request is held off by req_stall until the current one is back in IDLE; a request that
//   sends packets also passes POST to close out, and output stalls hold HDR, RUNV and LIT.
// Reset: synchronous, active high; clears control state, selects 8-bit units, buffer kept.
module packbits_rle_packer #(
   parameter int MAX_LITERAL = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_unit_value,
   input  logic        req_row_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_packed_unit,
   output logic        rsp_packed_last,
   output logic [15:0] rsp_packed_bytes,
   // unit size register
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_unit_size
);

   // The controller walks each request through decide, header, data and close-out
   // steps; the datapath holds the buffer state and does the arithmetic. They talk
   // only over these two bundles.
   prle_pkg::prle_cmd_type    cmd;
   prle_pkg::prle_status_type status;

   // Sequencer: hold off new requests until every unit of the current one has
   // reached the output register, which then drains on its own.
   prle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: literal buffer memory with registered read, fill and repeat
   // tracking, header formation, byte total and the output register that parts
   // the result channel from the sequencer.
   prle_datapath #(
      .MAX_LITERAL (MAX_LITERAL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_unit_value   (req_unit_value),
      .req_row_end      (req_row_end),
      .csr_write_enable (csr_write_enable),
      .csr_unit_size    (csr_unit_size),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_packed_unit  (rsp_packed_unit),
      .rsp_packed_last  (rsp_packed_last),
      .rsp_packed_bytes (rsp_packed_bytes),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

/* bench/tb_packbits_rle_packer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the PackBits run-length packer.
module tb_packbits_rle_packer;

   // Literal cap used for the instance and for the packed-stream predictor.
   localparam int LIT_CAP = 32;
   // Unit size code that the block treats as 32 bits.
   localparam logic [1:0] USZ_SPARE = 2'd3;
   // Idle cycles to allow after the last result before touching the size register,
   // covering a request that is still being decided but closes no packet.
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [31:0] value;
      logic        row_end;
   } src_unit_type;

   typedef struct packed {
      logic [31:0] word;
      logic        is_last;
      logic [15:0] byte_total;
   } packed_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_unit_value = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_packed_unit;
   logic        rsp_packed_last;
   logic [15:0] rsp_packed_bytes;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_unit_size = prle_pkg::USZ_8;

   // Requests waiting to be offered, and packed units still owed by the block.
   src_unit_type    pending_units[$];
   packed_word_type expected_words[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int units_queued = 0;
   logic [31:0] prev_drawn = '0;

   // Predictor state, reset once together with the block.
   logic [1:0]  size_cfg = prle_pkg::USZ_8;
   logic [31:0] lit_store [0:LIT_CAP];
   int unsigned fill_cnt = 0;
   int unsigned run_start = 0;
   bit          run_mode = 1'b0;
   bit          row_fresh = 1'b1;
   logic [31:0] last_unit = '0;
   int unsigned row_bytes = 0;

   packbits_rle_packer #(
      .MAX_LITERAL(LIT_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_unit_value(req_unit_value),
      .req_row_end(req_row_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_packed_unit(rsp_packed_unit),
      .rsp_packed_last(rsp_packed_last),
      .rsp_packed_bytes(rsp_packed_bytes),
      .csr_write_enable(csr_write_enable),
      .csr_unit_size(csr_unit_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Packed-stream predictor
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] width_mask(logic [1:0] sz);
      case (sz)
         prle_pkg::USZ_8:  return 32'h0000_00FF;
         prle_pkg::USZ_16: return 32'h0000_FFFF;
         default:          return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic int unsigned width_bytes(logic [1:0] sz);
      case (sz)
         prle_pkg::USZ_8:  return 1;
         prle_pkg::USZ_16: return 2;
         default:          return 4;
      endcase
   endfunction

   // Queue one packed unit, masked to the width in force now, and count its bytes.
   function automatic void put_word(logic [31:0] v);
      packed_word_type w;
      w.word = v & width_mask(size_cfg);
      w.is_last = 1'b0;
      w.byte_total = '0;
      expected_words.push_back(w);
      row_bytes += width_bytes(size_cfg);
      if (row_bytes > 32'hFFFF)
         row_bytes = 32'hFFFF;
   endfunction

   function automatic void flush_literal(int unsigned count);
      int unsigned i;
      put_word(32'(count - 1));
      for (i = 0; i < count && i <= LIT_CAP; i++)
         put_word(lit_store[i]);
   endfunction

   // Run header is the negated repeat count less one, two's complement at the width.
   function automatic void flush_run(int unsigned count, logic [31:0] v);
      put_word(32'(0) - 32'(count - 1));
      put_word(v);
   endfunction

   function automatic void restart_buffer(logic [31:0] c);
      lit_store[0] = c;
      fill_cnt = 1;
      run_start = 0;
      run_mode = 1'b0;
   endfunction

   // Advance the predictor by one accepted request and queue what it emits.
   function automatic void pack_unit(logic [31:0] raw, logic closes_row);
      logic [31:0]     c;
      packed_word_type tail;
      c = raw & width_mask(size_cfg);
      if (row_fresh) begin
         restart_buffer(c);
         row_bytes = 0;
         row_fresh = 1'b0;
      end else if (!run_mode) begin
         if (fill_cnt <= LIT_CAP)
            lit_store[fill_cnt] = c;
         fill_cnt++;
         if (fill_cnt > LIT_CAP) begin
            // literal full: send what is buffered, start again with this unit
            flush_literal(fill_cnt - 1);
            restart_buffer(c);
         end else if (c == last_unit) begin
            if (fill_cnt - run_start >= prle_pkg::MIN_RUN) begin
               if (run_start > 0)
                  flush_literal(run_start);
               run_mode = 1'b1;
            end else if (run_start == 0) begin
               run_mode = 1'b1;
            end
         end else begin
            run_start = fill_cnt - 1;
         end
      end else begin
         fill_cnt++;
         if (c != last_unit || fill_cnt - run_start > prle_pkg::MAX_RUN) begin
            flush_run(fill_cnt - 1 - run_start, last_unit);
            restart_buffer(c);
         end
      end
      last_unit = c;

      if (closes_row) begin
         if (run_mode)
            flush_run(fill_cnt - run_start, last_unit);
         else
            flush_literal(fill_cnt);
         // mark the closing unit of the row and attach the byte count
         tail = expected_words.pop_back();
         tail.is_last = 1'b1;
         tail.byte_total = row_bytes[15:0];
         expected_words.push_back(tail);
         row_fresh = 1'b1;
         run_mode = 1'b0;
         fill_cnt = 0;
         run_start = 0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: offer queued units, hold the payload while stalled
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      src_unit_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on the request taken at this edge, using the pre-edge payload
         if (req_valid && !req_stall)
            pack_unit(req_unit_value, req_row_end);
         if (!req_valid || !req_stall) begin
            if (pending_units.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_units.pop_front();
               req_valid <= 1'b1;
               req_unit_value <= nxt.value;
               req_row_end <= nxt.row_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: compare each taken unit with the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      packed_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("packed_unit with nothing expected: actual %h", rsp_packed_unit);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_packed_unit !== want.word) begin
                  $error("packed_unit: expected %h, actual %h", want.word, rsp_packed_unit);
                  mismatch_count++;
               end
               if (rsp_packed_last !== want.is_last) begin
                  $error("packed_last: expected %0d, actual %0d",
                         want.is_last, rsp_packed_last);
                  mismatch_count++;
               end
               if (rsp_packed_bytes !== want.byte_total) begin
                  $error("packed_bytes: expected %0d, actual %0d",
                         want.byte_total, rsp_packed_bytes);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic push_unit(logic [31:0] v, logic closes_row);
      src_unit_type u;
      u.value = v;
      u.row_end = closes_row;
      pending_units.push_back(u);
      units_queued++;
   endtask

   // Hold until every request is taken and every packed unit has come back,
   // then let the block settle on a request that emits nothing.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_units.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(logic [1:0] sz);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_unit_size <= sz;
      size_cfg = sz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mix of small values (accidental repeats), extremes, values equal only in the
   // low bits (masking decides the comparison) and full-width noise.
   function automatic logic [31:0] rand_unit();
      logic [31:0] v;
      case ($urandom_range(4))
         0: v = $urandom_range(3);
         1: begin
            case ($urandom_range(3))
               0:       v = 32'h0000_0000;
               1:       v = 32'hFFFF_FFFF;
               2:       v = 32'h8000_0080;
               default: v = 32'h7FFF_7F7F;
            endcase
         end
         2: v = prev_drawn ^ ($urandom & 32'hFFFF_FF00);
         default: v = $urandom;
      endcase
      prev_drawn = v;
      return v;
   endfunction

   function automatic int unsigned pick_run_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(1, 7);
      else if (r < 97)
         return $urandom_range(8, 24);
      else
         return $urandom_range(126, 132);
   endfunction

   // One row built from runs, literal stretches and short 0/1 noise.
   task automatic push_random_row();
      int unsigned  segs;
      int unsigned  kind;
      int unsigned  len;
      logic [31:0]  v;
      src_unit_type row[$];
      src_unit_type u;
      segs = $urandom_range(1, 4);
      u.row_end = 1'b0;
      repeat (segs) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            len = pick_run_len();
            v = rand_unit();
            u.value = v;
            repeat (len) row.push_back(u);
         end else if (kind < 85) begin
            len = $urandom_range(1, 40);
            repeat (len) begin
               u.value = rand_unit();
               row.push_back(u);
            end
         end else begin
            len = $urandom_range(1, 12);
            repeat (len) begin
               u.value = 32'($urandom_range(1));
               row.push_back(u);
            end
         end
      end
      foreach (row[i])
         push_unit(row[i].value, i == row.size() - 1);
   endtask

   // Optionally leave a row open so that the next size write lands mid-row.
   task automatic run_phase(logic [1:0] sz, int send_pct, int stall_in_pct, int n_units);
      int start_count;
      if ($urandom_range(1) == 1) begin
         repeat ($urandom_range(1, 5))
            push_unit(rand_unit(), 1'b0);
      end
      set_size(sz);
      send_idle_pct <= send_pct;
      stall_pct <= stall_in_pct;
      start_count = units_queued;
      while (units_queued - start_count < n_units)
         push_random_row();
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 8-bit units at reset width, no idling on either side.
      // a row of one unit; upper bits must be dropped
      push_unit(32'hFFFF_FFFF, 1'b1);
      // a repeat at the buffer start turns into a run at once; 0x100 masks to 0
      push_unit(32'h0000_0000, 1'b0);
      push_unit(32'h0000_0000, 1'b0);
      push_unit(32'h0000_0100, 1'b1);
      // literal of two, then a repeat reaching six becomes a run
      push_unit(32'd1, 1'b0);
      push_unit(32'd2, 1'b0);
      repeat (5) push_unit(32'd3, 1'b0);
      push_unit(32'd3, 1'b1);
      // short repeat inside a literal stays literal
      push_unit(32'd5, 1'b0);
      push_unit(32'd6, 1'b0);
      repeat (3) push_unit(32'd7, 1'b0);
      push_unit(32'd8, 1'b1);
      // run closed by a new unit, then a literal of one at row end
      push_unit(32'h0000_0009, 1'b0);
      push_unit(32'h0000_0009, 1'b0);
      push_unit(32'h0000_007F, 1'b1);

      // width changes inside a row: emitted units follow the width at emission
      push_unit(32'h1234_ABCD, 1'b0);
      push_unit(32'h5678_ABCD, 1'b0);
      set_size(prle_pkg::USZ_16);
      push_unit(32'h9999_ABCD, 1'b0);
      push_unit(32'h1111_3344, 1'b0);
      set_size(prle_pkg::USZ_32);
      push_unit(32'h1111_3344, 1'b1);

      // Random rows across widths and idling patterns; each phase boundary drains every
      // request and result before the size register is written.
      run_phase(prle_pkg::USZ_8, 0, 0, 25);
      run_phase(prle_pkg::USZ_16, 50, 0, 25);
      run_phase(USZ_SPARE, 0, 50, 25);
      run_phase(prle_pkg::USZ_32, 30, 30, 25);
      run_phase(prle_pkg::USZ_8, 30, 30, 25);
      run_phase(prle_pkg::USZ_32, 0, 0, 25);

      // run cap reached after a short literal
      push_unit(32'hA5A5_0001, 1'b0);
      push_unit(32'hA5A5_0002, 1'b0);
      push_unit(32'hA5A5_0003, 1'b0);
      repeat (130) push_unit(32'h5A5A_5A5A, 1'b0);
      push_unit(32'h0000_0000, 1'b1);

      wait_idle();
      if (mismatch_count == 0)
         $display("packbits_rle_packer regression: pass");
      else
         $display("packbits_rle_packer regression: fail");
      $finish;
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin
      #5_000_000;
      $display("packbits_rle_packer regression: fail");
      $finish;
   end

endmodule

/* packbits_rle_packer.f */
rtl/prle_pkg.sv
rtl/prle_ctrl.sv
rtl/prle_datapath.sv
rtl/packbits_rle_packer.sv
bench/tb_packbits_rle_packer.sv
